FILE: hw/rtl/tks_pkg.sv
`timescale 1ns / 1ps
package tks_pkg;

  localparam int ELEM_W  = 16;
  localparam int ACC_W   = 48;
  localparam int INV_W   = 32;
  localparam int NUM_W   = ACC_W + INV_W;   // magnitude times reciprocal
  localparam int DIV_W   = 26;              // 2*floor_sqrt of a 48-bit sum
  localparam int QCNT_W  = 7;               // counts NUM_W divide steps

  localparam int QUEUE_DEPTH = 4;
  localparam int QLVL_W      = 3;

  localparam logic [ACC_W-1:0] SCORE_POS_SAT = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] SCORE_NEG_SAT = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [ACC_W-1:0] SQRT_TOP_BIT  = {2'b01, {(ACC_W-2){1'b0}}};

  localparam logic       CMD_QUERY = 1'b0;
  localparam logic       CMD_ROW   = 1'b1;

  localparam logic [2:0] CFG_COSINE_MODE = 3'd0;
  localparam logic [2:0] CFG_INV_NORM    = 3'd1;
  localparam logic [2:0] CFG_VECTOR_DIM  = 3'd2;
  localparam logic [2:0] CFG_TOP_COUNT   = 3'd3;

  // one finished row (or a bare report request) handed to the back end
  typedef struct packed {
    logic                    has_row;
    logic                    report;
    logic signed [ACC_W-1:0] dot;
    logic        [ACC_W-1:0] sq;
  } row_entry_t;

  typedef struct packed {
    logic             cosine_mode;
    logic [INV_W-1:0] inv_norm;
  } score_cfg_t;

endpackage

FILE: hw/rtl/top_k_similarity_search.sv
`timescale 1ns / 1ps
// Input: one element per cycle while the row queue holds fewer than two rows, else busy.
// Back end per finished row: idle, compare and insert states in dot mode or for a zero sum of
// squares; in cosine mode also square root, low and high multiply, restoring divide, saturate.
// Rank 0 reaches the outputs once the last element has passed the front-end stage, the row
// queue and the back-end states, and queued rows are done; top_count results then follow back
// to back and cannot be stalled. Sync active-low reset clears counters, accumulators and the
// ranking; no memory sweep.
module top_k_similarity_search
  import tks_pkg::*;
#(
  parameter int DIM_MAX        = 1024,
  parameter int K_MAX          = 16,
  parameter int ROW_INDEX_BITS = 20
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_command,
  input  logic signed [ELEM_W-1:0] in_element,
  input  logic                     in_last_of_set,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [2:0]               cfg_index,
  input  logic [31:0]              cfg_data,
  output logic                     out_valid,
  output logic [3:0]               out_rank,
  output logic [19:0]              out_row_index,
  output logic signed [ACC_W-1:0]  out_score,
  output logic                     out_filled,
  output logic                     out_last
);

  localparam int CW = $clog2(DIM_MAX + 1);
  localparam int KW = $clog2(K_MAX + 1);

  logic             cosine_mode_r;
  logic [INV_W-1:0] inv_norm_r;
  logic [10:0]      vector_dim_r;
  logic [4:0]       top_count_r;

  logic [12:0]      dim_wide;
  logic [6:0]       k_wide;
  logic [CW-1:0]    dim_eff;
  logic [KW-1:0]    k_eff;
  score_cfg_t       score_cfg;

  logic              q_push, q_pop, q_empty;
  row_entry_t        q_in, q_head;
  logic [QLVL_W-1:0] q_level;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cosine_mode_r <= 1'b1;
      inv_norm_r    <= 32'd65536;
      vector_dim_r  <= 11'd1024;
      top_count_r   <= 5'd16;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_COSINE_MODE: cosine_mode_r <= cfg_data[0];
        CFG_INV_NORM:    inv_norm_r    <= cfg_data;
        CFG_VECTOR_DIM:  vector_dim_r  <= cfg_data[10:0];
        CFG_TOP_COUNT:   top_count_r   <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // clamp the dimension and rank count into their usable ranges
  assign dim_wide = {2'b00, vector_dim_r};
  assign k_wide   = {2'b00, top_count_r};
  assign dim_eff  = (vector_dim_r == '0) ? CW'(1) :
                    (dim_wide > 13'(DIM_MAX)) ? CW'(DIM_MAX) : CW'(dim_wide);
  assign k_eff    = (top_count_r == '0) ? KW'(1) :
                    (k_wide > 7'(K_MAX)) ? KW'(K_MAX) : KW'(k_wide);

  assign score_cfg.cosine_mode = cosine_mode_r;
  assign score_cfg.inv_norm    = inv_norm_r;

  tks_front #(
    .DIM_MAX (DIM_MAX),
    .CW      (CW)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_element     (in_element),
    .in_last_of_set (in_last_of_set),
    .dim            (dim_eff),
    .q_level        (q_level),
    .push           (q_push),
    .push_entry     (q_in)
  );

  tks_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .head_entry (q_head),
    .empty      (q_empty),
    .level      (q_level)
  );

  tks_back #(
    .K_MAX          (K_MAX),
    .ROW_INDEX_BITS (ROW_INDEX_BITS),
    .KW             (KW)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (score_cfg),
    .k             (k_eff),
    .head_entry    (q_head),
    .empty         (q_empty),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_rank      (out_rank),
    .out_row_index (out_row_index),
    .out_score     (out_score),
    .out_filled    (out_filled),
    .out_last      (out_last)
  );

endmodule

FILE: hw/rtl/tks_queue.sv
`timescale 1ns / 1ps
module tks_queue
  import tks_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  row_entry_t    push_entry,
  input  logic          pop,
  output row_entry_t    head_entry,
  output logic          empty,
  output logic [QLVL_W-1:0] level
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  row_entry_t        store [QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [QLVL_W-1:0] level_r;

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      level_r <= level_r + 1'b1;
      else if (pop && !push) level_r <= level_r - 1'b1;
    end
  end

  assign head_entry = store[rd_ptr_r];
  assign empty      = (level_r == '0);
  assign level      = level_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> level_r != QLVL_W'(QUEUE_DEPTH))
    else $error("row queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> level_r != '0)
    else $error("row queue underflow");

endmodule

FILE: hw/rtl/tks_front.sv
`timescale 1ns / 1ps
module tks_front
  import tks_pkg::*;
#(
  parameter int DIM_MAX = 1024,
  parameter int CW      = 11
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_command,
  input  logic signed [ELEM_W-1:0] in_element,
  input  logic                     in_last_of_set,
  input  logic [CW-1:0]            dim,
  input  logic [QLVL_W-1:0]        q_level,
  output logic                     push,
  output row_entry_t               push_entry
);

  localparam int AW = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;

  logic signed [ELEM_W-1:0] query_mem [DIM_MAX];

  logic [CW-1:0]            qcnt_r, ecnt_r;
  logic                     accept;
  logic [CW:0]              qcnt_inc, ecnt_inc;
  logic                     row_end;

  // second stage: one row element or a report request from a query element
  logic                     b_row_r, b_end_r, b_rpt_r, b_qlast_r;
  logic signed [ELEM_W-1:0] b_elem_r, b_query_r;
  logic signed [ACC_W-1:0]  dot_r, dot_nxt;
  logic        [ACC_W-1:0]  sq_r, sq_nxt;
  logic signed [2*ELEM_W-1:0] prod_dot, prod_sq;

  assign busy     = (q_level >= QLVL_W'(QUEUE_DEPTH - 2));
  assign accept   = start && !busy;
  assign qcnt_inc = {1'b0, qcnt_r} + 1'b1;
  assign ecnt_inc = {1'b0, ecnt_r} + 1'b1;
  assign row_end  = (ecnt_inc >= {1'b0, dim}) || in_last_of_set;

  always_ff @(posedge clk) begin
    if (accept && in_command == CMD_QUERY) begin
      query_mem[qcnt_r[AW-1:0]] <= in_element;
    end
    if (accept && in_command == CMD_ROW) begin
      b_query_r <= query_mem[ecnt_r[AW-1:0]];
      b_elem_r  <= in_element;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qcnt_r    <= '0;
      ecnt_r    <= '0;
      b_row_r   <= 1'b0;
      b_end_r   <= 1'b0;
      b_rpt_r   <= 1'b0;
      b_qlast_r <= 1'b0;
    end else begin
      b_row_r   <= accept && in_command == CMD_ROW;
      b_end_r   <= row_end;
      b_rpt_r   <= in_last_of_set;
      b_qlast_r <= accept && in_command == CMD_QUERY && in_last_of_set;
      if (accept) begin
        if (in_command == CMD_QUERY) begin
          qcnt_r <= (qcnt_inc >= {1'b0, dim}) ? '0 : qcnt_inc[CW-1:0];
          if (in_last_of_set) ecnt_r <= '0;
        end else begin
          ecnt_r <= row_end ? '0 : ecnt_inc[CW-1:0];
        end
      end
    end
  end

  assign prod_dot = b_query_r * b_elem_r;
  assign prod_sq  = b_elem_r * b_elem_r;
  assign dot_nxt  = dot_r + ACC_W'(prod_dot);
  assign sq_nxt   = sq_r + ACC_W'($unsigned(prod_sq));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r <= '0;
      sq_r  <= '0;
    end else if (b_qlast_r || (b_row_r && b_end_r)) begin
      dot_r <= '0;
      sq_r  <= '0;
    end else if (b_row_r) begin
      dot_r <= dot_nxt;
      sq_r  <= sq_nxt;
    end
  end

  always_comb begin
    push               = b_qlast_r || (b_row_r && b_end_r);
    push_entry.has_row = b_row_r;
    push_entry.report  = b_qlast_r || b_rpt_r;
    push_entry.dot     = dot_nxt;
    push_entry.sq      = sq_nxt;
  end

  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    !(b_row_r && b_qlast_r))
    else $error("row element and query report in the same stage");

endmodule

FILE: hw/rtl/tks_back.sv
`timescale 1ns / 1ps
module tks_back
  import tks_pkg::*;
#(
  parameter int K_MAX          = 16,
  parameter int ROW_INDEX_BITS = 20,
  parameter int KW             = 5
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  score_cfg_t               cfg,
  input  logic [KW-1:0]            k,
  input  row_entry_t               head_entry,
  input  logic                     empty,
  output logic                     pop,
  output logic                     out_valid,
  output logic [3:0]               out_rank,
  output logic [19:0]              out_row_index,
  output logic signed [ACC_W-1:0]  out_score,
  output logic                     out_filled,
  output logic                     out_last
);

  localparam int KIW = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int RB  = ROW_INDEX_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_SQRT, S_MUL_LO, S_MUL_HI, S_DIV, S_SAT, S_CMP, S_INS, S_REP
  } state_t;

  state_t                   state_r;
  logic signed [ACC_W-1:0]  rank_score [K_MAX];
  logic [RB-1:0]            best_row   [K_MAX];
  logic [K_MAX-1:0]         best_filled_r;
  logic [K_MAX-1:0]         keep_r;

  logic                     rpt_r, neg_r;
  logic signed [ACC_W-1:0]  score_r;
  logic [RB-1:0]            row_cnt_r, row_r;
  logic [ACC_W-1:0]         v_r, res_r, bit_r, mag_r;
  logic [DIV_W-1:0]         d_r, rem_r;
  logic [2*INV_W-1:0]       prod_lo_r;
  logic [NUM_W-1:0]         num_r;
  logic [QCNT_W-1:0]        step_r;
  logic [KIW-1:0]           idx_r;

  logic                     out_valid_r, out_filled_r, out_last_r;
  logic [3:0]               out_rank_r;
  logic [19:0]              out_row_r;
  logic signed [ACC_W-1:0]  out_score_r;

  logic [ACC_W-1:0]         sq_try;
  logic [DIV_W:0]           div_try;
  logic                     div_fit;
  logic [KW-1:0]            ins_pos;
  logic                     ins_found;
  logic                     q_big;

  assign pop = (state_r == S_IDLE) && !empty;

  assign sq_try  = res_r + bit_r;
  assign div_try = {rem_r, num_r[NUM_W-1]};
  assign div_fit = (div_try >= {1'b0, d_r});
  assign q_big   = |num_r[NUM_W-1:ACC_W-1];

  // first rank below k that is empty or that the new score beats; k means no entry
  always_comb begin
    ins_pos   = k;
    ins_found = 1'b0;
    for (int i = 0; i < K_MAX; i++) begin
      if (!ins_found && KW'(i) < k && !keep_r[i]) begin
        ins_pos   = KW'(i);
        ins_found = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      best_filled_r <= '0;
      row_cnt_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (!empty) begin
            rpt_r <= head_entry.report;
            neg_r <= head_entry.dot[ACC_W-1];
            mag_r <= head_entry.dot[ACC_W-1] ? ACC_W'(-head_entry.dot) : head_entry.dot;
            row_r <= row_cnt_r;
            if (head_entry.has_row) begin
              row_cnt_r <= row_cnt_r + 1'b1;
              if (cfg.cosine_mode && head_entry.sq != '0) begin
                v_r     <= head_entry.sq;
                res_r   <= '0;
                bit_r   <= SQRT_TOP_BIT;
                state_r <= S_SQRT;
              end else begin
                score_r <= cfg.cosine_mode ? '0 : head_entry.dot;
                state_r <= S_CMP;
              end
            end else begin
              idx_r   <= '0;
              state_r <= S_REP;
            end
          end
        end
        S_SQRT: begin
          if (bit_r == '0) begin
            d_r     <= DIV_W'(res_r << 1);
            state_r <= S_MUL_LO;
          end else begin
            if (v_r >= sq_try) begin
              v_r   <= v_r - sq_try;
              res_r <= (res_r >> 1) + bit_r;
            end else begin
              res_r <= res_r >> 1;
            end
            bit_r <= bit_r >> 2;
          end
        end
        S_MUL_LO: begin
          prod_lo_r <= mag_r[INV_W-1:0] * cfg.inv_norm;
          state_r   <= S_MUL_HI;
        end
        S_MUL_HI: begin
          num_r   <= NUM_W'(prod_lo_r)
                   + (NUM_W'(mag_r[ACC_W-1:INV_W] * cfg.inv_norm) << INV_W);
          rem_r   <= '0;
          step_r  <= QCNT_W'(NUM_W);
          state_r <= S_DIV;
        end
        S_DIV: begin
          // restoring divide, quotient shifts into the dividend register
          if (step_r == '0) begin
            state_r <= S_SAT;
          end else begin
            rem_r  <= div_fit ? DIV_W'(div_try - {1'b0, d_r}) : div_try[DIV_W-1:0];
            num_r  <= {num_r[NUM_W-2:0], div_fit};
            step_r <= step_r - 1'b1;
          end
        end
        S_SAT: begin
          if (neg_r) score_r <= q_big ? SCORE_NEG_SAT : -num_r[ACC_W-1:0];
          else       score_r <= q_big ? SCORE_POS_SAT : num_r[ACC_W-1:0];
          state_r <= S_CMP;
        end
        S_CMP: begin
          for (int i = 0; i < K_MAX; i++) begin
            keep_r[i] <= best_filled_r[i] && (rank_score[i] >= score_r);
          end
          state_r <= S_INS;
        end
        S_INS: begin
          for (int i = 0; i < K_MAX; i++) begin
            if (KW'(i) < k && ins_pos < k) begin
              if (KW'(i) == ins_pos) begin
                rank_score[i]    <= score_r;
                best_row[i]      <= row_r;
                best_filled_r[i] <= 1'b1;
              end else if (KW'(i) > ins_pos && i > 0) begin
                rank_score[i]    <= rank_score[(i > 0) ? i - 1 : 0];
                best_row[i]      <= best_row[(i > 0) ? i - 1 : 0];
                best_filled_r[i] <= best_filled_r[(i > 0) ? i - 1 : 0];
              end
            end
          end
          idx_r   <= '0;
          state_r <= rpt_r ? S_REP : S_IDLE;
        end
        S_REP: begin
          out_valid_r  <= 1'b1;
          out_rank_r   <= 4'(idx_r);
          out_filled_r <= best_filled_r[idx_r];
          out_row_r    <= best_filled_r[idx_r] ? 20'(best_row[idx_r]) : '0;
          out_score_r  <= best_filled_r[idx_r] ? rank_score[idx_r] : '0;
          out_last_r   <= (KW'(idx_r) + 1'b1 == k);
          if (KW'(idx_r) + 1'b1 == k) begin
            best_filled_r <= '0;
            row_cnt_r     <= '0;
            state_r       <= S_IDLE;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_rank      = out_rank_r;
  assign out_row_index = out_row_r;
  assign out_score     = out_score_r;
  assign out_filled    = out_filled_r;
  assign out_last      = out_last_r;

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |=> !out_valid_r)
    else $error("result strobe directly after the last rank");

  a_run_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !$past(out_valid_r) |-> out_rank_r == 4'd0)
    else $error("report run does not start at rank zero");

endmodule

FILE: tb/sv/tb_top_k_similarity_search.sv
`timescale 1ns / 1ps
module tb_top_k_similarity_search;
  import tks_pkg::*;

  localparam int DIM_MAX = 1024;
  localparam int K_MAX = 16;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [3:0]  rank;
    logic [19:0] row_index;
    logic [47:0] score;
    logic        filled;
    logic        last;
  } rank_entry_t;

  typedef struct {
    logic        cmd;
    logic [15:0] elem;
    logic        last_of_set;
    logic        fixed;      // expected report typed in below
    logic [47:0] fixed_score;
    logic        fixed_filled;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_command = 1'b0;
  logic signed [15:0] in_element = '0;
  logic in_last_of_set = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic out_valid;
  logic [3:0] out_rank;
  logic [19:0] out_row_index;
  logic signed [47:0] out_score;
  logic out_filled;
  logic out_last;

  top_k_similarity_search DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_element(in_element), .in_last_of_set(in_last_of_set),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .out_valid(out_valid), .out_rank(out_rank),
    .out_row_index(out_row_index), .out_score(out_score), .out_filled(out_filled),
    .out_last(out_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic        mdl_cosine;
  logic [31:0] mdl_inv_norm;
  logic [10:0] mdl_dim;
  logic [4:0]  mdl_k;
  logic signed [15:0] query_mem [DIM_MAX];
  logic signed [63:0] dot_acc, sq_acc;
  int unsigned elem_cnt, query_cnt;
  logic [19:0] row_cnt;
  logic signed [47:0] rank_score [K_MAX];
  logic [19:0] best_row [K_MAX];
  logic best_full [K_MAX];

  rank_entry_t pending_ranks[$];
  int errors = 0;
  int unsigned cycles = 0;
  int unsigned queries_written = 0;  // query entries ever stored

  function automatic int unsigned dim_now();
    if (mdl_dim == 0) return 1;
    if (mdl_dim > DIM_MAX) return DIM_MAX;
    return mdl_dim;
  endfunction

  function automatic int unsigned k_now();
    if (mdl_k == 0) return 1;
    if (mdl_k > K_MAX) return K_MAX;
    return mdl_k;
  endfunction

  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [47:0] cos_value(logic signed [63:0] dot,
                                                  logic signed [63:0] sq);
    logic [63:0] mag, div;
    logic [127:0] prod, quo;
    logic neg;
    if (sq <= 0) return '0;
    neg = dot < 0;
    mag = neg ? -dot : dot;
    div = 2 * isqrt(sq);
    prod = {64'd0, mag} * {96'd0, mdl_inv_norm};
    quo = prod / {64'd0, div};
    if (neg) return (quo >= (128'd1 << 47)) ? SCORE_NEG_SAT : -$signed(quo[47:0]);
    return (quo > 128'h7FFF_FFFF_FFFF) ? SCORE_POS_SAT : quo[47:0];
  endfunction

  task automatic close_row();
    int unsigned pos;
    logic signed [47:0] s;
    logic [19:0] row;
    pos = k_now() - 1;
    s = mdl_cosine ? cos_value(dot_acc, sq_acc) : dot_acc[47:0];
    row = row_cnt;
    row_cnt = row_cnt + 1;
    dot_acc = 0; sq_acc = 0; elem_cnt = 0;
    if (best_full[pos] && !(s > rank_score[pos])) return;
    while (pos > 0 && (!best_full[pos-1] || rank_score[pos-1] < s)) begin
      rank_score[pos] = rank_score[pos-1];
      best_row[pos] = best_row[pos-1];
      best_full[pos] = best_full[pos-1];
      pos--;
    end
    rank_score[pos] = s;
    best_row[pos] = row;
    best_full[pos] = 1'b1;
  endtask

  task automatic clear_ranking();
    for (int i = 0; i < K_MAX; i++) begin
      best_full[i] = 0; rank_score[i] = 0; best_row[i] = 0;
    end
    row_cnt = 0;
    dot_acc = 0; sq_acc = 0; elem_cnt = 0;
  endtask

  task automatic predict_item(logic cmd, logic signed [15:0] e, logic lst);
    rank_entry_t r;
    logic signed [15:0] qv;
    int unsigned kk;
    if (cmd == CMD_QUERY) begin
      if (query_cnt < DIM_MAX) query_mem[query_cnt] = e;
      query_cnt++;
      if (query_cnt >= dim_now()) query_cnt = 0;
      if (lst) begin
        dot_acc = 0; sq_acc = 0; elem_cnt = 0;
      end
    end else begin
      qv = elem_cnt < DIM_MAX ? query_mem[elem_cnt] : 16'sd0;
      dot_acc = dot_acc + 64'(qv) * 64'(e);
      sq_acc = sq_acc + 64'(e) * 64'(e);
      elem_cnt++;
      if (elem_cnt >= dim_now() || lst) close_row();
    end
    if (!lst) return;
    kk = k_now();
    for (int i = 0; i < kk; i++) begin
      r.rank = i[3:0];
      r.filled = best_full[i];
      r.row_index = best_full[i] ? best_row[i] : '0;
      r.score = best_full[i] ? rank_score[i] : '0;
      r.last = (i + 1 == kk);
      pending_ranks.push_back(r);
    end
    clear_ranking();
  endtask

  // results
  always @(posedge clk) begin
    rank_entry_t exp_r;
    if (rst_n && out_valid) begin
      if (pending_ranks.size() == 0) begin
        $display("%0t: unexpected result rank %0d row %0d score %0d", $time, out_rank,
                 out_row_index, out_score);
        errors++;
      end else begin
        exp_r = pending_ranks.pop_front();
        if (exp_r.rank !== out_rank || exp_r.row_index !== out_row_index ||
            exp_r.score !== out_score || exp_r.filled !== out_filled ||
            exp_r.last !== out_last) begin
          $display("%0t: mismatch expected rank %0d row %0d score %0d filled %0d last %0d",
                   $time, exp_r.rank, exp_r.row_index, $signed(exp_r.score), exp_r.filled,
                   exp_r.last);
          $display("%0t:          actual   rank %0d row %0d score %0d filled %0d last %0d",
                   $time, out_rank, out_row_index, out_score, out_filled, out_last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  logic quiet_sender = 1'b0;

  // start stays high into the next item; drain drops it when the sender stops
  task automatic send_item(logic cmd, logic [15:0] e, logic lst);
    while (!quiet_sender && $urandom_range(99) < 20) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_command <= cmd;
    in_element <= e;
    in_last_of_set <= lst;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_item(cmd, e, lst);
  endtask

  // only the report strobes leave the block; let the back end settle before a write
  task automatic drain();
    start <= 1'b0;
    while (pending_ranks.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_COSINE_MODE: mdl_cosine = val[0];
      CFG_INV_NORM:    mdl_inv_norm = val;
      CFG_VECTOR_DIM:  mdl_dim = val[10:0];
      CFG_TOP_COUNT:   mdl_k = val[4:0];
      default: ;
    endcase
  endtask

  task automatic set_mode(logic cos, logic [31:0] inv, logic [10:0] d, logic [4:0] k);
    drain();
    write_reg(CFG_COSINE_MODE, {31'd0, cos});
    write_reg(CFG_INV_NORM, inv);
    write_reg(CFG_VECTOR_DIM, {21'd0, d});
    write_reg(CFG_TOP_COUNT, {27'd0, k});
    cfg_valid <= 1'b0;
  endtask

  // fill the whole query so every row element reads a written entry
  task automatic load_query();
    int unsigned n;
    n = dim_now();
    for (int i = 0; i < n; i++) send_item(CMD_QUERY, 16'($urandom), 1'b0);
    if (n > queries_written) queries_written = n;
  endtask

  task automatic random_set(int unsigned rows, logic extremes);
    int unsigned n;
    logic [15:0] e;
    n = dim_now();
    for (int r = 0; r < rows; r++) begin
      for (int i = 0; i < n; i++) begin
        e = extremes ? ($urandom_range(1) ? 16'h7FFF : 16'h8000) : 16'($urandom);
        // occasionally cut the last row short
        if (r == rows - 1 && i + 1 < n && $urandom_range(9) == 0) begin
          send_item(CMD_ROW, e, 1'b1);
          return;
        end
        send_item(CMD_ROW, e, (r == rows - 1 && i == n - 1));
      end
    end
  endtask

  stim_row_t directed[$];

  initial begin
    rank_entry_t r;
    int unsigned total;
    mdl_cosine = 1; mdl_inv_norm = 32'd65536; mdl_dim = 11'd1024; mdl_k = 5'd16;
    for (int i = 0; i < DIM_MAX; i++) query_mem[i] = '0;
    query_cnt = 0;
    clear_ranking();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // dim 1, k 2, dot mode: scores readable by eye
    set_mode(1'b0, 32'd65536, 11'd1, 5'd2);
    directed = '{
      '{CMD_QUERY, 16'h7FFF, 1'b1, 1'b1, 48'd0, 1'b0},          // report on query, empty
      '{CMD_ROW,   16'h7FFF, 1'b0, 1'b0, 48'd0, 1'b0},
      '{CMD_ROW,   16'h8000, 1'b0, 1'b0, 48'd0, 1'b0},
      '{CMD_ROW,   16'h7FFF, 1'b1, 1'b1, 48'h3FFF_0001, 1'b1},  // tie: earlier row ahead
      '{CMD_QUERY, 16'h8000, 1'b0, 1'b0, 48'd0, 1'b0},
      '{CMD_ROW,   16'h8000, 1'b0, 1'b0, 48'd0, 1'b0},
      '{CMD_ROW,   16'h0000, 1'b1, 1'b1, 48'h4000_0000, 1'b1}
    };
    foreach (directed[j]) begin
      send_item(directed[j].cmd, directed[j].elem, directed[j].last_of_set);
      if (directed[j].fixed && pending_ranks.size() != 0) begin
        r = pending_ranks[pending_ranks.size() - (mdl_k)];
        if (r.filled !== directed[j].fixed_filled ||
            (r.filled && r.score !== directed[j].fixed_score)) begin
          $display("%0t: predictor expected score %0h filled %0d got %0h %0d", $time,
                   directed[j].fixed_score, directed[j].fixed_filled, r.score, r.filled);
          errors++;
        end
      end
    end
    queries_written = 1;

    // cosine with extremes, then out-of-range counts
    set_mode(1'b1, 32'hFFFF_FFFF, 11'd3, 5'd16);
    load_query();
    random_set(4, 1'b1);
    random_set(1, 1'b0);
    set_mode(1'b1, 32'd0, 11'd0, 5'd0);
    load_query();
    random_set(2, 1'b0);
    set_mode(1'b0, 32'd1, 11'd2, 5'd31);
    load_query();
    random_set(18, 1'b0);

    // pause until every report has come out
    drain();

    total = 0;
    for (int ph = 0; ph < 8; ph++) begin
      set_mode(1'($urandom_range(1)), (ph == 2) ? 32'hFFFF_FFFF : $urandom,
               11'($urandom_range(1, 6)), 5'($urandom_range(1, 16)));
      load_query();
      quiet_sender = (ph == 4);
      while (total < 30 * (ph + 1)) begin
        random_set($urandom_range(1, 6), $urandom_range(9) == 0);
        total += 10;
      end
    end
    quiet_sender = 0;
    // one wider set
    set_mode(1'b1, 32'd65536, 11'd40, 5'd16);
    load_query();
    random_set(2, 1'b0);

    drain();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
